>>> design/blvm_pkg.sv
// Package for the battery low-voltage monitor.
// Holds field widths, fixed-point scaling and divider constants, and register indexes.
// Has no dependencies.
package blvm_pkg;

    localparam int ADC_W     = 12;
    localparam int MV_W      = 16;
    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 24;

    localparam int FULL_SCALE_MV = 36300;
    localparam int ADC_MAX       = 4095;

    // Sample scaling: s = adc * SCALE_INT + round(adc * SCALE_REM / ADC_MAX).
    localparam int SCALE_NUM   = FULL_SCALE_MV * (2 ** FRAC_BITS);
    localparam int SCALE_INT   = SCALE_NUM / ADC_MAX;
    localparam int SCALE_REM   = SCALE_NUM % ADC_MAX;
    localparam int ROUND_W     = 23;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 25;
    localparam longint SCALE_RECIP =
        ((longint'(1) << RECIP_SHIFT) + longint'(ADC_MAX) - 1) / longint'(ADC_MAX);
    localparam int SCALE_PROD_W = ROUND_W + RECIP_W;

    // Filter: acc = floor((FILT_KEEP * acc + s + FILT_ROUND) / FILT_DIV).
    localparam int FILT_KEEP   = 9;
    localparam int FILT_DIV    = 10;
    localparam int FILT_ROUND  = FILT_DIV / 2;
    localparam int SUM_W       = 27;
    localparam int DIV_SHIFT   = 30;
    localparam int DIV_RECIP_W = 27;
    localparam longint DIV_RECIP =
        ((longint'(1) << DIV_SHIFT) + longint'(FILT_DIV) - 1) / longint'(FILT_DIV);
    localparam int DIV_PROD_W  = SUM_W + DIV_RECIP_W;

    localparam int ACC_MAX = SCALE_NUM;

    localparam int TICKS_PER_CHECK = 20;
    localparam int TRIP_COUNT      = 5;
    localparam int DECAY_SHIFT     = 2;
    localparam int TICK_W          = $clog2(TICKS_PER_CHECK + 1);
    localparam int UNDER_W         = $clog2(TRIP_COUNT + 1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_MV     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 1'd1;

    localparam logic [MV_W-1:0] LOWER_MV_RESET     = 16'd11100;
    localparam logic            ALARM_ENABLE_RESET = 1'b1;

endpackage

>>> design/battery_low_voltage_monitor_unit.sv
// A result moves through the input, mid, scaling and output registers after its input beat is accepted.
// Throughput: one beat per cycle; every stage stalls together while a result waits.
// The filter divide-by-ten multiplier lies in the combinational state update loop from acc_reg back to itself.
// Reset (rst_n, asynchronous, active low) clears the filter, counters, flag and
// pipeline valids, and loads lower_mv = 11100 and alarm_enable = 1.
// Depends on blvm_pkg.
module battery_low_voltage_monitor_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [blvm_pkg::ADC_W-1:0]        adc_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [blvm_pkg::MV_W-1:0]         filtered_mv,
    output logic                              undervolt_flag,
    output logic                              alarm_pulse,
    input  logic                              cfg_we,
    input  logic [blvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [blvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                                  advance;

    logic [blvm_pkg::MV_W-1:0]             lower_mv_reg;
    logic                                  alarm_enable_reg;

    logic                                  in_valid_reg;
    logic                                  cmd_in_reg;
    logic [blvm_pkg::ADC_W-1:0]            adc_reg;

    logic                                  mid_valid_reg;
    logic                                  cmd_mid_reg;
    logic [blvm_pkg::ACC_W-1:0]            base_reg;
    logic [blvm_pkg::ACC_W-1:0]            base_next;
    logic [blvm_pkg::ROUND_W-1:0]          round_reg;
    logic [blvm_pkg::ROUND_W-1:0]          round_next;

    logic                                  scl_valid_reg;
    logic                                  cmd_scl_reg;
    logic [blvm_pkg::ACC_W-1:0]            scaled_reg;
    logic [blvm_pkg::ACC_W-1:0]            scaled_next;
    logic [blvm_pkg::SCALE_PROD_W-1:0]     scale_prod;

    logic                                  out_valid_reg;
    logic                                  alarm_pulse_reg;
    logic                                  alarm_pulse_next;

    logic [blvm_pkg::ACC_W-1:0]            acc_reg;
    logic [blvm_pkg::ACC_W-1:0]            acc_next;
    logic [blvm_pkg::TICK_W-1:0]           tick_count_reg;
    logic [blvm_pkg::TICK_W-1:0]           tick_count_next;
    logic [blvm_pkg::UNDER_W-1:0]          under_count_reg;
    logic [blvm_pkg::UNDER_W-1:0]          under_count_next;
    logic                                  low_flag_reg;
    logic                                  low_flag_next;

    logic [blvm_pkg::SUM_W-1:0]            filt_sum;
    logic [blvm_pkg::DIV_PROD_W-1:0]       div_prod;
    logic [blvm_pkg::TICK_W-1:0]           tick_inc;
    logic [blvm_pkg::UNDER_W-1:0]          under_step;
    logic                                  is_under;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_mv_reg     <= blvm_pkg::LOWER_MV_RESET;
            alarm_enable_reg <= blvm_pkg::ALARM_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                blvm_pkg::REG_LOWER_MV:
                begin
                    lower_mv_reg <= cfg_data[blvm_pkg::MV_W-1:0];
                end
                blvm_pkg::REG_ALARM_ENABLE:
                begin
                    alarm_enable_reg <= cfg_data[0];
                end
            endcase
        end
    end

    // Scaling, first half: integer part and rounded remainder numerator.
    assign base_next = blvm_pkg::ACC_W'(
        blvm_pkg::ACC_W'(adc_reg) * blvm_pkg::ACC_W'(blvm_pkg::SCALE_INT));
    assign round_next = blvm_pkg::ROUND_W'(
        blvm_pkg::ROUND_W'(adc_reg) * blvm_pkg::ROUND_W'(blvm_pkg::SCALE_REM)
        + blvm_pkg::ROUND_W'(blvm_pkg::ADC_MAX / 2));

    // Scaling, second half: remainder divided by the ADC full scale by reciprocal.
    assign scale_prod = blvm_pkg::SCALE_PROD_W'(round_reg)
                      * blvm_pkg::SCALE_PROD_W'(blvm_pkg::SCALE_RECIP);
    assign scaled_next = base_reg + blvm_pkg::ACC_W'(
        scale_prod[blvm_pkg::SCALE_PROD_W-1:blvm_pkg::RECIP_SHIFT]);

    // Filter update, divided by ten through a reciprocal multiply.
    assign filt_sum = blvm_pkg::SUM_W'(acc_reg) * blvm_pkg::SUM_W'(blvm_pkg::FILT_KEEP)
                    + blvm_pkg::SUM_W'(scaled_reg)
                    + blvm_pkg::SUM_W'(blvm_pkg::FILT_ROUND);
    assign div_prod = blvm_pkg::DIV_PROD_W'(filt_sum)
                    * blvm_pkg::DIV_PROD_W'(blvm_pkg::DIV_RECIP);

    assign tick_inc = tick_count_reg + blvm_pkg::TICK_W'(1);
    assign is_under = acc_reg <= {lower_mv_reg, blvm_pkg::FRAC_BITS'(0)};
    assign under_step = is_under ? under_count_reg + blvm_pkg::UNDER_W'(1)
                                 : under_count_reg >> blvm_pkg::DECAY_SHIFT;

    always_comb
    begin
        acc_next         = acc_reg;
        tick_count_next  = tick_count_reg;
        under_count_next = under_count_reg;
        low_flag_next    = low_flag_reg;
        alarm_pulse_next = 1'b0;
        if (cmd_scl_reg == blvm_pkg::CMD_SAMPLE)
        begin
            acc_next = div_prod[blvm_pkg::DIV_SHIFT +: blvm_pkg::ACC_W];
        end
        else if (tick_inc == blvm_pkg::TICK_W'(blvm_pkg::TICKS_PER_CHECK))
        begin
            tick_count_next = '0;
            if (under_step == blvm_pkg::UNDER_W'(blvm_pkg::TRIP_COUNT))
            begin
                under_count_next = '0;
                if (alarm_enable_reg)
                begin
                    low_flag_next    = 1'b1;
                    alarm_pulse_next = 1'b1;
                end
            end
            else
            begin
                under_count_next = under_step;
            end
        end
        else
        begin
            tick_count_next = tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            mid_valid_reg   <= 1'b0;
            scl_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            alarm_pulse_reg <= 1'b0;
            acc_reg         <= '0;
            tick_count_reg  <= '0;
            under_count_reg <= '0;
            low_flag_reg    <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= in_valid;
            mid_valid_reg <= in_valid_reg;
            scl_valid_reg <= mid_valid_reg;
            out_valid_reg <= scl_valid_reg;
            if (scl_valid_reg)
            begin
                alarm_pulse_reg <= alarm_pulse_next;
                acc_reg         <= acc_next;
                tick_count_reg  <= tick_count_next;
                under_count_reg <= under_count_next;
                low_flag_reg    <= low_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_in_reg  <= cmd;
            adc_reg     <= adc_sample;
            cmd_mid_reg <= cmd_in_reg;
            base_reg    <= base_next;
            round_reg   <= round_next;
            cmd_scl_reg <= cmd_mid_reg;
            scaled_reg  <= scaled_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_mv    = acc_reg[blvm_pkg::FRAC_BITS +: blvm_pkg::MV_W];
    assign undervolt_flag = low_flag_reg;
    assign alarm_pulse    = alarm_pulse_reg;

    a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && alarm_pulse_reg |-> low_flag_reg)
        else $error("Alarm pulse without the low-voltage flag.");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        low_flag_reg |=> low_flag_reg)
        else $error("Low-voltage flag cleared without reset.");

    a_under_bound: assert property (@(posedge clk) disable iff (!rst_n)
        under_count_reg < blvm_pkg::UNDER_W'(blvm_pkg::TRIP_COUNT))
        else $error("Debounce count reached the trip count between beats.");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg < blvm_pkg::TICK_W'(blvm_pkg::TICKS_PER_CHECK))
        else $error("Tick count out of range.");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= blvm_pkg::ACC_W'(blvm_pkg::ACC_MAX))
        else $error("Filter value above full scale.");

endmodule

>>> test/battery_low_voltage_monitor_unit_tb.sv
// Testbench for battery_low_voltage_monitor_unit: a directed table and randomized phases of
// samples and ticks, with every output beat checked against a table value or a behavioral monitor model.
// Depends on blvm_pkg and the battery_low_voltage_monitor_unit RTL.
module battery_low_voltage_monitor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int MAX_WAIT    = 19;
    localparam int SETTLE      = 8;

    localparam longint unsigned MV_PER_FULL_SCALE = 36300;
    localparam longint unsigned COUNTS_FULL_SCALE = 4095;
    localparam int              ACC_FRAC          = 8;
    localparam int              CHECK_EVERY       = 20;
    localparam int              TRIP_AT           = 5;

    typedef struct packed {
        logic [blvm_pkg::MV_W-1:0] mv;
        logic                      low;
        logic                      pulse;
    } reading_t;

    typedef struct {
        logic                       op;
        logic [blvm_pkg::ADC_W-1:0] adc;
        bit                         known;
        reading_t                   want;
    } directed_row_t;

    typedef struct {
        logic [blvm_pkg::MV_W-1:0] lower;
        logic                      enable;
        int                        count;
        int                        tick_pct;
        int                        center;
        int                        spread;
        bit                        gaps;
        bit                        stalls;
    } phase_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            cmd;
    logic [blvm_pkg::ADC_W-1:0]      adc_sample;
    logic                            out_valid;
    logic                            out_ready;
    logic [blvm_pkg::MV_W-1:0]       filtered_mv;
    logic                            undervolt_flag;
    logic                            alarm_pulse;
    logic                            cfg_we;
    logic [blvm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [blvm_pkg::CFG_DATA_W-1:0] cfg_data;

    reading_t pending_readings[$];
    int       fail_count = 0;
    int       reports = 0;
    int       cycle_count = 0;
    bit       gaps_on = 1'b1;
    bit       stalls_on = 1'b1;

    logic [blvm_pkg::ACC_W-1:0] filt_acc = '0;
    int                         ticks_seen = 0;
    int                         debounce = 0;
    bit                         sticky_low = 1'b0;
    logic [blvm_pkg::MV_W-1:0]  threshold_mv = 16'd11100;
    bit                         alarm_on = 1'b1;

    battery_low_voltage_monitor_unit DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_mv    (filtered_mv),
        .undervolt_flag (undervolt_flag),
        .alarm_pulse    (alarm_pulse),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic reading_t advance_monitor(logic op, logic [blvm_pkg::ADC_W-1:0] adc);
        longint unsigned scaled;
        longint unsigned acc_next;
        reading_t        r;
        r.pulse = 1'b0;
        if (op == blvm_pkg::CMD_SAMPLE)
        begin
            scaled = (longint'(adc) * MV_PER_FULL_SCALE * (64'd1 << ACC_FRAC)
                      + COUNTS_FULL_SCALE / 2) / COUNTS_FULL_SCALE;
            acc_next = (9 * longint'(filt_acc) + scaled + 5) / 10;
            filt_acc = acc_next[blvm_pkg::ACC_W-1:0];
        end
        else
        begin
            ticks_seen++;
            if (ticks_seen >= CHECK_EVERY)
            begin
                ticks_seen = 0;
                if (longint'(filt_acc) <= (longint'(threshold_mv) << ACC_FRAC))
                    debounce++;
                else
                    debounce = debounce / 4;
                if (debounce >= TRIP_AT)
                begin
                    debounce = 0;
                    if (alarm_on)
                    begin
                        sticky_low = 1'b1;
                        r.pulse = 1'b1;
                    end
                end
            end
        end
        r.mv  = filt_acc[blvm_pkg::ACC_W-1:ACC_FRAC];
        r.low = sticky_low;
        return r;
    endfunction

    task automatic push_beat(logic op, logic [blvm_pkg::ADC_W-1:0] adc, bit known,
                             reading_t want);
        int       gap;
        reading_t predicted;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        repeat (gap)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = op;
        adc_sample = adc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_monitor(op, adc);
        pending_readings.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_readings();
        in_valid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [blvm_pkg::CFG_IDX_W-1:0] idx,
                             logic [blvm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == blvm_pkg::REG_LOWER_MV)
            threshold_mv = data;
        else
            alarm_on = data[0];
    endtask

    initial
    begin : reading_sink
        int       stall_left;
        reading_t got;
        reading_t want;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.mv    = filtered_mv;
                got.low   = undervolt_flag;
                got.pulse = alarm_pulse;
                if (pending_readings.size() == 0)
                begin
                    fail_count++;
                    if (reports < MAX_REPORTS)
                    begin
                        reports++;
                        $display("unexpected beat: mv=%0d low=%0b pulse=%0b",
                                 got.mv, got.low, got.pulse);
                    end
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.mv !== want.mv || got.low !== want.low
                        || got.pulse !== want.pulse)
                    begin
                        fail_count++;
                        if (reports < MAX_REPORTS)
                        begin
                            reports++;
                            $display({"mismatch: expected mv=%0d low=%0b pulse=%0b, ",
                                      "got mv=%0d low=%0b pulse=%0b"},
                                     want.mv, want.low, want.pulse,
                                     got.mv, got.low, got.pulse);
                        end
                    end
                end
                stall_left = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t rows[24];
        phase_t        phases[7];
        logic          op;
        int            level;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = blvm_pkg::CMD_SAMPLE;
        adc_sample = '0;
        cfg_we     = 1'b0;
        cfg_index  = blvm_pkg::REG_LOWER_MV;
        cfg_data   = '0;

        rows = '{
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b1, '{16'd0,    1'b0, 1'b0}},
            '{blvm_pkg::CMD_SAMPLE, 12'd0,    1'b1, '{16'd0,    1'b0, 1'b0}},
            '{blvm_pkg::CMD_SAMPLE, 12'd4095, 1'b1, '{16'd3630, 1'b0, 1'b0}},
            '{blvm_pkg::CMD_TICK,   12'd4095, 1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd4095, 1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd1,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd4094, 1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'h800,  1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'h7FF,  1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'hAAA,  1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'hAAA,  1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'h555,  1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'h555,  1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd4095, 1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_SAMPLE, 12'd1354, 1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0},
            '{blvm_pkg::CMD_TICK,   12'd0,    1'b0, '0}
        };

        phases = '{
            '{16'd11100, 1'b1, 250, 60, 2048, 2048, 1'b1, 1'b1},
            '{16'hFFFF,  1'b1, 350, 92, 2048, 2048, 1'b0, 1'b0},
            '{16'hFFFF,  1'b0, 250, 92, 2048, 2048, 1'b1, 1'b0},
            '{16'd12000, 1'b1, 350, 85, 1354, 250,  1'b0, 1'b1},
            '{16'd36300, 1'b1, 400, 50, 4095, 0,    1'b1, 1'b1},
            '{16'd0,     1'b1, 150, 80, 0,    40,   1'b0, 1'b0},
            '{16'd20000, 1'b1, 250, 88, 2256, 150,  1'b1, 1'b1}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            push_beat(rows[i].op, rows[i].adc, rows[i].known, rows[i].want);

        foreach (phases[p])
        begin
            drain_readings();
            write_reg(blvm_pkg::REG_LOWER_MV, phases[p].lower);
            write_reg(blvm_pkg::REG_ALARM_ENABLE, {15'($urandom), phases[p].enable});
            gaps_on   = phases[p].gaps;
            stalls_on = phases[p].stalls;
            repeat (phases[p].count)
            begin
                op = ($urandom_range(1, 100) <= phases[p].tick_pct) ? blvm_pkg::CMD_TICK
                                                                     : blvm_pkg::CMD_SAMPLE;
                level = phases[p].center + int'($urandom_range(0, 2 * phases[p].spread))
                        - phases[p].spread;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                push_beat(op, level[blvm_pkg::ADC_W-1:0], 1'b0, '0);
            end
        end
        drain_readings();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
